FILE: rtl/core/tcd_pkg.sv
// tcd_pkg: shared types, constants and the arctangent table of the tilt and crash detector
// used by every module in rtl/core; depends on nothing
`default_nettype none

package tcd_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ACC_W   = 10;  // raw axis and offset width
  localparam int CORR_W  = 11;  // corrected axis width
  localparam int NUM_W   = 12;  // angle numerator, holds the negated x
  localparam int SQ_W    = 23;  // sum of two squares, signed
  localparam int RAD_W   = 42;  // square root radicand
  localparam int ROOT_W  = 21;
  localparam int REM_W   = 23;
  localparam int VEC_W   = 26;  // cordic x and y
  localparam int Z_W     = 25;  // cordic angle, Q16 degrees
  localparam int DEG_W   = 8;   // whole degrees
  localparam int ANG_W   = 16;  // Q8.8 filtered angle
  localparam int LIM_W   = 15;
  localparam int STEP_W  = 5;
  localparam int ROOT_STEPS = 21;
  localparam int ANGLE_MAX  = 23040;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 15;

  typedef enum logic [3:0] {
    S_IDLE, S_SQUARE, S_ROOT, S_VEC_INIT, S_VEC, S_ANGLE, S_FILTER, S_DONE
  } state_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_X_OFFSET, REG_Y_OFFSET, REG_Z_OFFSET, REG_TILT_LIMIT,
    REG_DECEL_LIMIT, REG_Z_LOW, REG_Z_HIGH
  } cfg_reg_t;

  typedef struct packed {
    logic              capture;
    logic              square;
    logic              root_step;
    logic              vec_init;
    logic              vec_step;
    logic              angle;
    logic              filter;
    logic              publish;
    logic              sel_pitch;
    logic [STEP_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

  // atan(2^-i) in degrees, Q16
  function automatic logic [21:0] atan_q16(input logic [STEP_W-1:0] i);
    logic [21:0] v;
    case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117305;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tcd_ctrl.sv
// tcd_ctrl: sequencer for the tilt and crash detector
// depends on tcd_pkg; drives tcd_datapath through cmd_t
`default_nettype none

module tcd_ctrl #(
  parameter int CORDIC_STEPS = tcd_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire tcd_pkg::status_t status,
  output tcd_pkg::cmd_t         cmd
);

  tcd_pkg::state_t             state, state_next;
  logic                        sel, sel_next;
  logic [tcd_pkg::STEP_W-1:0]  cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcd_pkg::S_IDLE;
      sel   <= 1'b0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      sel   <= sel_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next    = state;
    sel_next      = sel;
    cnt_next      = cnt;
    cmd           = '0;
    cmd.sel_pitch = sel;
    cmd.step      = cnt;
    in_ready      = 1'b0;
    case (state)
      tcd_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          sel_next    = 1'b0;
          state_next  = tcd_pkg::S_SQUARE;
        end
      end
      tcd_pkg::S_SQUARE: begin
        cmd.square = 1'b1;
        cnt_next   = '0;
        state_next = tcd_pkg::S_ROOT;
      end
      tcd_pkg::S_ROOT: begin
        cmd.root_step = 1'b1;
        cnt_next      = cnt + 1'b1;
        if (cnt == tcd_pkg::STEP_W'(tcd_pkg::ROOT_STEPS - 1)) begin
          state_next = tcd_pkg::S_VEC_INIT;
        end
      end
      tcd_pkg::S_VEC_INIT: begin
        cmd.vec_init = 1'b1;
        cnt_next     = '0;
        state_next   = tcd_pkg::S_VEC;
      end
      tcd_pkg::S_VEC: begin
        cmd.vec_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == tcd_pkg::STEP_W'(CORDIC_STEPS - 1)) begin
          state_next = tcd_pkg::S_ANGLE;
        end
      end
      tcd_pkg::S_ANGLE: begin
        cmd.angle  = 1'b1;
        state_next = tcd_pkg::S_FILTER;
      end
      tcd_pkg::S_FILTER: begin
        cmd.filter = 1'b1;
        if (sel) begin
          state_next = tcd_pkg::S_DONE;
        end else begin
          sel_next   = 1'b1;
          state_next = tcd_pkg::S_SQUARE;
        end
      end
      tcd_pkg::S_DONE: begin
        if (!status.out_busy) begin
          cmd.publish = 1'b1;
          state_next  = tcd_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = tcd_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/tcd_datapath.sv
// tcd_datapath: offsets, square root, vectoring cordic, angle filters, alarms, result register
// depends on tcd_pkg; commanded by tcd_ctrl
`default_nettype none

module tcd_datapath (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire tcd_pkg::cmd_t                      cmd,
  output tcd_pkg::status_t                        status,
  input  wire logic                               cfg_we,
  input  wire logic [tcd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire logic [tcd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic signed [tcd_pkg::ACC_W-1:0]   accel_x,
  input  wire logic signed [tcd_pkg::ACC_W-1:0]   accel_y,
  input  wire logic signed [tcd_pkg::ACC_W-1:0]   accel_z,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [tcd_pkg::ANG_W-1:0]        roll_filtered,
  output logic signed [tcd_pkg::ANG_W-1:0]        pitch_filtered,
  output logic                                    flip_alarm,
  output logic                                    decel_alarm
);

  localparam int CW = tcd_pkg::CORR_W;
  localparam int AW = tcd_pkg::ACC_W;

  // configuration
  logic signed [AW-1:0]              x_off, y_off, z_off;
  logic [tcd_pkg::LIM_W-1:0]         tilt_limit;
  logic signed [CW-1:0]              decel_limit, z_low, z_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_off       <= -10'sd10;
      y_off       <= 10'sd100;
      z_off       <= 10'sd13;
      tilt_limit  <= 15'd384;
      decel_limit <= -11'sd100;
      z_low       <= 11'sd206;
      z_high      <= 11'sd306;
    end else if (cfg_we) begin
      case (cfg_addr)
        tcd_pkg::REG_X_OFFSET:    x_off       <= cfg_data[AW-1:0];
        tcd_pkg::REG_Y_OFFSET:    y_off       <= cfg_data[AW-1:0];
        tcd_pkg::REG_Z_OFFSET:    z_off       <= cfg_data[AW-1:0];
        tcd_pkg::REG_TILT_LIMIT:  tilt_limit  <= cfg_data;
        tcd_pkg::REG_DECEL_LIMIT: decel_limit <= cfg_data[CW-1:0];
        tcd_pkg::REG_Z_LOW:       z_low       <= cfg_data[CW-1:0];
        tcd_pkg::REG_Z_HIGH:      z_high      <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // corrected axes
  logic signed [CW-1:0] cx, cy, cz;
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cx <= CW'(accel_x) + CW'(x_off);
      cy <= CW'(accel_y) + CW'(y_off);
      cz <= CW'(accel_z) + CW'(z_off);
    end
  end

  // squares and square root, one result bit per step
  logic signed [tcd_pkg::SQ_W-1:0]   a_ext, b_ext, sq;
  logic signed [tcd_pkg::NUM_W-1:0]  num;
  logic [tcd_pkg::RAD_W-1:0]         rad;
  logic [tcd_pkg::REM_W-1:0]         rem;
  logic [tcd_pkg::ROOT_W-1:0]        root;
  logic [tcd_pkg::REM_W+1:0]         rem_t, trial;
  logic                              ge;

  assign a_ext = cmd.sel_pitch ? tcd_pkg::SQ_W'(cy) : tcd_pkg::SQ_W'(cx);
  assign b_ext = tcd_pkg::SQ_W'(cz);
  assign sq    = a_ext * a_ext + b_ext * b_ext;
  assign rem_t = {rem, rad[tcd_pkg::RAD_W-1 -: 2]};
  assign trial = {2'b00, root, 2'b01};
  assign ge    = rem_t >= trial;

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      rad  <= {sq[21:0], 20'd0};
      rem  <= '0;
      root <= '0;
      num  <= cmd.sel_pitch ? -tcd_pkg::NUM_W'(cx) : tcd_pkg::NUM_W'(cy);
    end else if (cmd.root_step) begin
      rad  <= rad << 2;
      rem  <= ge ? tcd_pkg::REM_W'(rem_t - trial) : tcd_pkg::REM_W'(rem_t);
      root <= {root[tcd_pkg::ROOT_W-2:0], ge};
    end
  end

  // vectoring cordic
  logic signed [tcd_pkg::VEC_W-1:0] xv, yv, xs, ys;
  logic signed [tcd_pkg::Z_W-1:0]   zacc, atan_s;
  logic                             zero_den;

  assign xs     = xv >>> cmd.step;
  assign ys     = yv >>> cmd.step;
  assign atan_s = tcd_pkg::Z_W'(tcd_pkg::atan_q16(cmd.step));

  always_ff @(posedge clk) begin
    if (cmd.vec_init) begin
      xv       <= tcd_pkg::VEC_W'({1'b0, root});
      yv       <= tcd_pkg::VEC_W'(num) <<< 10;
      zacc     <= '0;
      zero_den <= (root == '0);
    end else if (cmd.vec_step) begin
      if (!yv[tcd_pkg::VEC_W-1] && (yv != '0)) begin
        xv   <= xv + ys;
        yv   <= yv - xs;
        zacc <= zacc + atan_s;
      end else if (yv[tcd_pkg::VEC_W-1]) begin
        xv   <= xv - ys;
        yv   <= yv + xs;
        zacc <= zacc - atan_s;
      end
    end
  end

  // whole degrees, truncated toward zero and clamped
  logic [tcd_pkg::Z_W-1:0]          zmag;
  logic [8:0]                       whole, whole_c;
  logic signed [tcd_pkg::DEG_W-1:0] deg_v, deg;

  assign zmag    = zacc[tcd_pkg::Z_W-1] ? tcd_pkg::Z_W'(-zacc) : tcd_pkg::Z_W'(zacc);
  assign whole   = zmag[24:16];
  assign whole_c = (whole > 9'd90) ? 9'd90 : whole;

  always_comb begin
    if (zero_den) begin
      if (num > 0)      deg_v = 8'sd90;
      else if (num < 0) deg_v = -8'sd90;
      else              deg_v = 8'sd0;
    end else if (zacc[tcd_pkg::Z_W-1]) begin
      deg_v = -tcd_pkg::DEG_W'(whole_c);
    end else begin
      deg_v = tcd_pkg::DEG_W'(whole_c);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.angle) begin
      deg <= deg_v;
    end
  end

  // first-order filters, 0.94 and 0.06 in Q16, rounded half up
  logic signed [tcd_pkg::ANG_W-1:0] roll_state, pitch_state, f_old, f_new;
  logic signed [33:0]               facc, fshift;

  assign f_old  = cmd.sel_pitch ? pitch_state : roll_state;
  assign facc   = 34'(f_old) * 34'sd61604 + 34'(deg) * 34'sd1006592 + 34'sd32768;
  assign fshift = facc >>> 16;
  assign f_new  = (fshift > 34'sd23040)  ? tcd_pkg::ANG_W'(tcd_pkg::ANGLE_MAX) :
                  (fshift < -34'sd23040) ? -tcd_pkg::ANG_W'(tcd_pkg::ANGLE_MAX) :
                  tcd_pkg::ANG_W'(fshift);

  always_ff @(posedge clk) begin
    if (rst) begin
      roll_state  <= '0;
      pitch_state <= '0;
    end else if (cmd.filter) begin
      if (cmd.sel_pitch) pitch_state <= f_new;
      else               roll_state  <= f_new;
    end
  end

  // alarms
  logic [tcd_pkg::ANG_W-1:0] abs_roll, abs_pitch;
  logic                      flip_v, decel_v;

  assign abs_roll  = roll_state[tcd_pkg::ANG_W-1]  ? tcd_pkg::ANG_W'(-roll_state)  :
                                                     tcd_pkg::ANG_W'(roll_state);
  assign abs_pitch = pitch_state[tcd_pkg::ANG_W-1] ? tcd_pkg::ANG_W'(-pitch_state) :
                                                     tcd_pkg::ANG_W'(pitch_state);
  assign flip_v  = (abs_pitch > tcd_pkg::ANG_W'(tilt_limit)) || !(cz > z_low) ||
                   !(cz < z_high);
  assign decel_v = (cy < decel_limit) || (abs_roll > tcd_pkg::ANG_W'(tilt_limit));

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      roll_filtered  <= roll_state;
      pitch_filtered <= pitch_state;
      flip_alarm     <= flip_v;
      decel_alarm    <= decel_v;
    end
  end

  assign status.out_busy = out_valid && !out_ready;

endmodule

`default_nettype wire

FILE: rtl/core/tilt_crash_detector_top.sv
// tilt_crash_detector_top: top level of the tilt and crash detector
// depends on tcd_pkg, tcd_ctrl and tcd_datapath
`default_nettype none

// usage
// - input channel in_valid / in_ready carries one raw sample (accel_x, accel_y, accel_z)
// - output channel out_valid / out_ready carries one result item per input item:
//   filtered roll and pitch in Q8.8 degrees plus flip and deceleration alarms
// - configuration: cfg_we writes cfg_data into register cfg_addr at once, no read-back;
//   writes to indexes beyond the register list are ignored
// - each item runs two angle passes on one shared square root and cordic unit:
//   per pass 1 square + 21 root steps + 1 load + CORDIC_STEPS rotations + 1 angle
//   + 1 filter, then one publish step, after which out_valid rises
// - one item at a time; in_ready is high only while the sequencer is idle, so
//   a new sample is taken only after the previous one has been published
// - the result sits in an output register; the next item is taken while it waits,
//   and a stalled receiver only holds the sequencer at its final publish step
// - reset clears both filter states to zero, restores the default configuration
//   and empties the output register

module tilt_crash_detector_top #(
  parameter int CORDIC_STEPS = tcd_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [tcd_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  wire logic [tcd_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [tcd_pkg::ACC_W-1:0]    accel_x,
  input  wire logic signed [tcd_pkg::ACC_W-1:0]    accel_y,
  input  wire logic signed [tcd_pkg::ACC_W-1:0]    accel_z,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [tcd_pkg::ANG_W-1:0]         roll_filtered,
  output logic signed [tcd_pkg::ANG_W-1:0]         pitch_filtered,
  output logic                                     flip_alarm,
  output logic                                     decel_alarm
);

  // command and status between sequencer and datapath
  tcd_pkg::cmd_t    cmd;
  tcd_pkg::status_t status;

  tcd_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tcd_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_data       (cfg_data),
    .accel_x        (accel_x),
    .accel_y        (accel_y),
    .accel_z        (accel_z),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .roll_filtered  (roll_filtered),
    .pitch_filtered (pitch_filtered),
    .flip_alarm     (flip_alarm),
    .decel_alarm    (decel_alarm)
  );

endmodule

`default_nettype wire

FILE: rtl/core/tcd_checker.sv
// tcd_checker: port-level assertions for the tilt and crash detector
// depends on tcd_pkg; bound to tilt_crash_detector_top
`default_nettype none

module tcd_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                in_valid,
  input wire logic                                in_ready,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic signed [tcd_pkg::ANG_W-1:0]    roll_filtered,
  input wire logic signed [tcd_pkg::ANG_W-1:0]    pitch_filtered
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(roll_filtered) &&
    $stable(pitch_filtered))
    else $error("result changed while stalled");

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // no result without work in between
  a_no_result_from_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready && $past(in_ready) && !$past(out_valid) |-> !out_valid)
    else $error("result appeared with no item");

  // filtered angles stay within plus or minus ninety degrees
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> roll_filtered <= 16'sd23040 && roll_filtered >= -16'sd23040 &&
    pitch_filtered <= 16'sd23040 && pitch_filtered >= -16'sd23040)
    else $error("filtered angle out of range");

endmodule

bind tilt_crash_detector_top tcd_checker u_tcd_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .roll_filtered  (roll_filtered),
  .pitch_filtered (pitch_filtered)
);

`default_nettype wire

FILE: tb/tb.sv
// tb: self-checking testbench for tilt_crash_detector_top
// holds its own tilt/filter/alarm predictor; depends on tcd_pkg and the rtl
`timescale 1ns / 100ps

module tb;
  import tcd_pkg::*;

  // result item as the block presents it
  typedef struct packed {
    logic signed [ANG_W-1:0] roll;
    logic signed [ANG_W-1:0] pitch;
    logic                    flip;
    logic                    decel;
  } tilt_result_t;

  // raw sample item
  typedef struct packed {
    logic signed [ACC_W-1:0] ax;
    logic signed [ACC_W-1:0] ay;
    logic signed [ACC_W-1:0] az;
  } sample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [ACC_W-1:0] accel_x = '0, accel_y = '0, accel_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [ANG_W-1:0] roll_filtered, pitch_filtered;
  logic flip_alarm, decel_alarm;

  tilt_crash_detector_top dut (
    .clk, .rst, .cfg_we, .cfg_addr, .cfg_data,
    .in_valid, .in_ready, .accel_x, .accel_y, .accel_z,
    .out_valid, .out_ready, .roll_filtered, .pitch_filtered,
    .flip_alarm, .decel_alarm
  );

  // clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: configuration copy and the two filter states
  int off_x, off_y, off_z, lim_tilt, lim_decel, band_lo, band_hi;
  int roll_f, pitch_f;

  sample_t      sample_q[$];   // items waiting for the driver
  tilt_result_t expected_q[$]; // predicted results, oldest first
  int  errors = 0;
  int  cycles = 0;
  bit  calm = 1'b0;            // no idling on either side once set
  longint unsigned atan_tab[24] = '{2949120, 1740967, 919879, 466945, 234379,
    117305, 58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0};

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint int_root(longint n);
    longint r = 0, b = 64'd1 << 46;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // whole degrees of atan(num / sqrt(a^2 + b^2)) via vectoring cordic
  function automatic int tilt_deg(int num, int a, int b);
    longint xv, yv, z, xs, ys, d;
    xv = int_root((longint'(a) * a + longint'(b) * b) << 20);
    yv = longint'(num) * 1024;
    z = 0;
    if (xv == 0) return (num > 0) ? 90 : (num < 0) ? -90 : 0;
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      xs = floor_shift(xv, i);
      ys = floor_shift(yv, i);
      if (yv > 0) begin
        xv += ys; yv -= xs; z += atan_tab[i];
      end else if (yv < 0) begin
        xv -= ys; yv += xs; z -= atan_tab[i];
      end
    end
    d = (z >= 0) ? z / 65536 : -((-z) / 65536);
    if (d > 90) d = 90;
    if (d < -90) d = -90;
    return int'(d);
  endfunction

  // 0.94 / 0.06 low-pass in Q8.8, rounded half up, clamped
  function automatic int smooth(int f, int a);
    longint r = floor_shift(longint'(61604) * f + longint'(3932) * 256 * a + 32768, 16);
    if (r > ANGLE_MAX) r = ANGLE_MAX;
    if (r < -ANGLE_MAX) r = -ANGLE_MAX;
    return int'(r);
  endfunction

  task automatic predict_tilt(sample_t s);
    int cx, cy, cz, ap, ar;
    tilt_result_t r;
    cx = int'(s.ax) + off_x;
    cy = int'(s.ay) + off_y;
    cz = int'(s.az) + off_z;
    roll_f = smooth(roll_f, tilt_deg(cy, cx, cz));
    pitch_f = smooth(pitch_f, tilt_deg(-cx, cy, cz));
    ap = pitch_f < 0 ? -pitch_f : pitch_f;
    ar = roll_f < 0 ? -roll_f : roll_f;
    r.roll = roll_f[ANG_W-1:0];
    r.pitch = pitch_f[ANG_W-1:0];
    r.flip = (ap > lim_tilt) || !(cz > band_lo) || !(cz < band_hi);
    r.decel = (cy < lim_decel) || (ar > lim_tilt);
    expected_q.push_back(r);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // input handshake seen at the rising edge, used by the driver at the next falling edge
  bit in_took = 1'b0;
  always @(posedge clk) begin
    in_took <= !rst && in_valid && in_ready;
  end

  // driver: takes items off the queue, idles in random bursts
  int in_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_took) begin
        predict_tilt(sample_q.pop_front());
      end
      if (!(in_valid && !in_took)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          in_gap = $urandom_range(1, 13);
          in_valid <= 1'b0;
        end else if (sample_q.size() > 0) begin
          in_valid <= 1'b1;
          accel_x <= sample_q[0].ax;
          accel_y <= sample_q[0].ay;
          accel_z <= sample_q[0].az;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stalls
  int out_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_gap = $urandom_range(1, 13);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor: compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    tilt_result_t w;
    cycles++;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        w = expected_q.pop_front();
        if (roll_filtered !== w.roll) report_mismatch("roll", roll_filtered, w.roll);
        if (pitch_filtered !== w.pitch) report_mismatch("pitch", pitch_filtered, w.pitch);
        if (flip_alarm !== w.flip) report_mismatch("flip", flip_alarm, w.flip);
        if (decel_alarm !== w.decel) report_mismatch("decel", decel_alarm, w.decel);
      end
    end
    if (cycles > 1500000) begin
      $display("tb failed");
      $finish;
    end
  end

  // register write at a falling edge, mirrored into the predictor
  task automatic write_reg(cfg_reg_t idx, int val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    case (idx)
      REG_X_OFFSET:    off_x = int'($signed(val[ACC_W-1:0]));
      REG_Y_OFFSET:    off_y = int'($signed(val[ACC_W-1:0]));
      REG_Z_OFFSET:    off_z = int'($signed(val[ACC_W-1:0]));
      REG_TILT_LIMIT:  lim_tilt = val & 32'h7FFF;
      REG_DECEL_LIMIT: lim_decel = int'($signed(val[CORR_W-1:0]));
      REG_Z_LOW:       band_lo = int'($signed(val[CORR_W-1:0]));
      REG_Z_HIGH:      band_hi = int'($signed(val[CORR_W-1:0]));
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until every queued item is taken and every result has come back
  task automatic drain();
    while (sample_q.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic sample_t pick(int lo, int hi);
    sample_t s;
    s.ax = ACC_W'(int'($urandom_range(0, hi - lo)) + lo);
    s.ay = ACC_W'(int'($urandom_range(0, hi - lo)) + lo);
    s.az = ACC_W'(int'($urandom_range(0, hi - lo)) + lo);
    return s;
  endfunction

  function automatic sample_t mk(int x, int y, int z);
    sample_t s;
    s.ax = ACC_W'(x); s.ay = ACC_W'(y); s.az = ACC_W'(z);
    return s;
  endfunction

  initial begin
    int ex;
    sample_t s;
    off_x = -10; off_y = 100; off_z = 13;
    lim_tilt = 384; lim_decel = -100; band_lo = 206; band_hi = 306;
    roll_f = 0; pitch_f = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: extremes and the zero-denominator cases at reset defaults
    sample_q.push_back(mk(10, -100, -13));   // all axes zero after offsets
    sample_q.push_back(mk(110, -100, -13));  // roll denominator nonzero, pitch -90
    sample_q.push_back(mk(-90, -100, -13));  // pitch +90
    sample_q.push_back(mk(10, 0, -13));      // roll +90, pitch numerator zero
    sample_q.push_back(mk(10, -200, -13));   // roll -90
    sample_q.push_back(mk(-512, -512, -512));
    sample_q.push_back(mk(511, 511, 511));
    sample_q.push_back(mk(0, 0, 256));
    sample_q.push_back(mk(-512, 511, 0));
    sample_q.push_back(mk(511, -512, 0));
    drain();

    // extreme configuration, unknown index ignored
    write_reg(REG_X_OFFSET, -512);
    write_reg(REG_Y_OFFSET, 511);
    write_reg(REG_Z_OFFSET, -512);
    write_reg(REG_TILT_LIMIT, 32767);
    write_reg(REG_DECEL_LIMIT, -1024);
    write_reg(REG_Z_LOW, -1024);
    write_reg(REG_Z_HIGH, 1023);
    write_reg(cfg_reg_t'(7), 0);
    for (int i = 0; i < 10; i++) sample_q.push_back(pick(-512, 511));
    sample_q.push_back(mk(-512, -512, -512));
    sample_q.push_back(mk(511, 511, 511));
    drain();

    // random phases, each under a new setting
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_X_OFFSET, $urandom_range(0, 1023) - 512);
      write_reg(REG_Y_OFFSET, $urandom_range(0, 1023) - 512);
      write_reg(REG_Z_OFFSET, $urandom_range(0, 1023) - 512);
      write_reg(REG_TILT_LIMIT, ph == 0 ? 0 : (ph == 1 ? 23040 : $urandom_range(0, 6000)));
      write_reg(REG_DECEL_LIMIT, ph == 2 ? 1023 : $urandom_range(0, 2047) - 1024);
      write_reg(REG_Z_LOW, $urandom_range(0, 600) - 300);
      write_reg(REG_Z_HIGH, $urandom_range(0, 600));
      if (ph == 5) calm = 1'b1;
      for (int i = 0; i < 310; i++) begin
        ex = $urandom_range(0, 9);
        if (ex == 0) s = pick(-512, 511);
        else if (ex == 1) s = mk($urandom_range(0, 1) ? -512 : 511,
                                 $urandom_range(0, 1) ? -512 : 511,
                                 $urandom_range(0, 1) ? -512 : 511);
        else s = pick(-300, 300);
        sample_q.push_back(s);
      end
      drain();
    end

    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule

FILE: sim.f
rtl/core/tcd_pkg.sv
rtl/core/tcd_ctrl.sv
rtl/core/tcd_datapath.sv
rtl/core/tilt_crash_detector_top.sv
rtl/core/tcd_checker.sv
tb/tb.sv
